// File: rtl/mshd_pkg.sv
`timescale 1ns / 1ps

package mshd_pkg;

    // Stick readings are centered on this code
    localparam logic [7:0] STICK_CENTER = 8'd128;

    // Rotation term is (w * geometry_sum) / ROT_DIVISOR, truncated toward zero.
    // The divide is done as (|p| >> 2) / 5 with a reciprocal multiply.
    localparam int unsigned ROT_DIVISOR  = 20;
    localparam int unsigned RECIP_SHIFT  = 18;
    localparam logic [15:0] RECIP_FIVE   = 16'd52429;   // ceil(2^18 / 5)

    localparam logic [7:0] DUTY_MAX = 8'd255;

    // Register reset values
    localparam logic [6:0] STICK_DB_RST = 7'd5;
    localparam logic [7:0] MOTOR_DB_RST = 8'd5;
    localparam logic [9:0] GEOMETRY_RST = 10'd20;

    typedef enum logic [1:0] {
        REG_STICK_DB = 2'd0,
        REG_MOTOR_DB = 2'd1,
        REG_GEOMETRY = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [6:0] stick_deadband;
        logic [7:0] motor_deadband;
        logic [9:0] geometry_sum;
    } cfg_t;

    typedef struct packed {
        logic [7:0] strafe_stick;
        logic [7:0] forward_stick;
        logic [7:0] turn_stick;
    } sample_t;

    typedef struct packed {
        logic       wheel1_fwd;
        logic       wheel1_rev;
        logic [7:0] wheel1_duty;
        logic       wheel2_fwd;
        logic       wheel2_rev;
        logic [7:0] wheel2_duty;
        logic       wheel3_fwd;
        logic       wheel3_rev;
        logic [7:0] wheel3_duty;
        logic       wheel4_fwd;
        logic       wheel4_rev;
        logic [7:0] wheel4_duty;
    } drive_t;

    // Between the two pipeline stages: centered, deadbanded offsets and the
    // raw rotation product w * geometry_sum (|p| <= 128 * 1023).
    typedef struct packed {
        logic signed [8:0]  vx;
        logic signed [8:0]  vy;
        logic signed [17:0] rot_prod;
    } prep_t;

endpackage

// File: rtl/mshd_cfg.sv
`timescale 1ns / 1ps

module mshd_cfg
    import mshd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [9:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_STICK_DB: cfg_next.stick_deadband = wr_data[6:0];
                REG_MOTOR_DB: cfg_next.motor_deadband = wr_data[7:0];
                REG_GEOMETRY: cfg_next.geometry_sum   = wr_data[9:0];
                default:      cfg_next = cfg_reg;   // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_deadband <= STICK_DB_RST;
            cfg_reg.motor_deadband <= MOTOR_DB_RST;
            cfg_reg.geometry_sum   <= GEOMETRY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/mshd_prep.sv
`timescale 1ns / 1ps

module mshd_prep
    import mshd_pkg::*;
(
    input  sample_t    sample,
    input  logic [6:0] stick_deadband,
    input  logic [9:0] geometry_sum,
    output prep_t      prep
);

    function automatic logic signed [8:0] stick_offset(
        input logic [7:0] raw,
        input logic [6:0] db
    );
        logic signed [8:0] v;
        logic signed [8:0] d;
        begin
            v = $signed({1'b0, raw}) - $signed({1'b0, STICK_CENTER});
            d = $signed({2'b00, db});
            if (v > -d && v < d)
                v = '0;
            return v;
        end
    endfunction

    logic signed [8:0]  w;
    logic signed [19:0] prod_full;

    always_comb
    begin
        prep.vx   = stick_offset(sample.strafe_stick, stick_deadband);
        prep.vy   = stick_offset(sample.forward_stick, stick_deadband);
        w         = stick_offset(sample.turn_stick, stick_deadband);
        // 9b signed x 11b signed; magnitude stays below 2^17
        prod_full = w * $signed({1'b0, geometry_sum});
        prep.rot_prod = prod_full[17:0];
    end

endmodule

// File: rtl/mshd_mix.sv
`timescale 1ns / 1ps

module mshd_mix
    import mshd_pkg::*;
(
    input  prep_t      prep,
    input  logic [7:0] motor_deadband,
    output drive_t     drive
);

    typedef struct packed {
        logic       fwd;
        logic       rev;
        logic [7:0] duty;
    } bridge_t;

    function automatic bridge_t bridge(
        input logic signed [14:0] s,
        input logic [7:0]         db
    );
        logic signed [14:0] d;
        logic signed [14:0] m;
        bridge_t            b;
        begin
            d = $signed({7'b0, db});
            m = -s;
            if (s >= d)
            begin
                b.fwd  = 1'b1;
                b.rev  = 1'b0;
                b.duty = (s > $signed({7'b0, DUTY_MAX})) ? DUTY_MAX : s[7:0];
            end
            else if (s <= -d)
            begin
                b.fwd  = 1'b0;
                b.rev  = 1'b1;
                b.duty = (m > $signed({7'b0, DUTY_MAX})) ? DUTY_MAX : m[7:0];
            end
            else
            begin
                b.fwd  = 1'b0;
                b.rev  = 1'b1;
                b.duty = '0;
            end
            return b;
        end
    endfunction

    logic               neg;
    logic [16:0]        mag;
    logic [14:0]        quarter;
    logic [30:0]        recip_prod;
    logic [12:0]        quot;
    logic signed [14:0] r;
    logic signed [14:0] vx;
    logic signed [14:0] vy;
    logic signed [14:0] sum1;
    logic signed [14:0] sum2;
    logic signed [14:0] sum3;
    logic signed [14:0] sum4;
    logic signed [14:0] s1;
    logic signed [14:0] s2;
    logic signed [14:0] s3;
    logic signed [14:0] s4;
    bridge_t            b1;
    bridge_t            b2;
    bridge_t            b3;
    bridge_t            b4;

    always_comb
    begin
        // |p| / 20 = (|p| >> 2) / 5, divide by 5 via reciprocal (exact below 2^15)
        neg        = prep.rot_prod[17];
        mag        = neg ? 17'(-prep.rot_prod) : prep.rot_prod[16:0];
        quarter    = mag[16:2];
        recip_prod = quarter * RECIP_FIVE;
        quot       = recip_prod[30:RECIP_SHIFT];
        r          = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});

        vx = 15'(prep.vx);
        vy = 15'(prep.vy);

        sum1 = vy - vx + r;
        sum2 = vy + vx - r;
        sum3 = vx - vy + r;     // wheel 3 mirrored: negated speed
        sum4 = vy + vx + r;

        s1 = {sum1[13:0], 1'b0};
        s2 = {sum2[13:0], 1'b0};
        s3 = {sum3[13:0], 1'b0};
        s4 = {sum4[13:0], 1'b0};

        b1 = bridge(s1, motor_deadband);
        b2 = bridge(s2, motor_deadband);
        b3 = bridge(s3, motor_deadband);
        b4 = bridge(s4, motor_deadband);

        drive.wheel1_fwd  = b1.fwd;
        drive.wheel1_rev  = b1.rev;
        drive.wheel1_duty = b1.duty;
        drive.wheel2_fwd  = b2.fwd;
        drive.wheel2_rev  = b2.rev;
        drive.wheel2_duty = b2.duty;
        drive.wheel3_fwd  = b3.fwd;
        drive.wheel3_rev  = b3.rev;
        drive.wheel3_duty = b3.duty;
        drive.wheel4_fwd  = b4.fwd;
        drive.wheel4_rev  = b4.rev;
        drive.wheel4_duty = b4.duty;
    end

endmodule

// File: rtl/mecanum_stick_to_hbridge_drive.sv
`timescale 1ns / 1ps

// Mecanum stick mixer: three raw stick readings in, four H-bridge commands out.
// Channels:
//   sample  - valid/ready input, one transfer per stick sample (sample_t)
//   drive   - valid/ready output, one transfer per sample (drive_t)
//   cfg     - valid/ready register writes: 0 stick deadband, 1 motor deadband,
//             2 geometry sum; other indexes are dropped. cfg_ready is always 1.
//             Write only while no sample is in flight.
// Pipeline: two registers. Stage 1 centers the sticks, applies the stick
// deadband and forms w * geometry_sum; stage 2 divides by 20 (reciprocal
// multiply), mixes the four wheel speeds and maps each onto fwd/rev/duty.
// Path: an accepted sample is registered in prep_reg, then in drive_reg.
// Throughput: one transfer per cycle while drive_ready is high, set by the
// two-stage pipeline; each stage holds one item and has its own valid bit.
// Stall: when drive_ready is low the result stays put; stage 1 still takes
// one more sample if empty, then sample_ready drops until the output drains.
// Reset: both valid bits clear, registers return to deadbands 5/5 and
// geometry 20.
module mecanum_stick_to_hbridge_drive
    import mshd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       sample_valid,
    output logic       sample_ready,
    input  sample_t    sample,

    output logic       drive_valid,
    input  logic       drive_ready,
    output drive_t     drive,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);

    cfg_t   cfg;

    prep_t  prep_comb;
    prep_t  prep_reg;
    logic   prep_valid_reg;
    logic   prep_valid_next;

    drive_t drive_comb;
    drive_t drive_reg;
    logic   drive_valid_reg;
    logic   drive_valid_next;

    logic   out_free;
    logic   take;

    // Config registers
    assign cfg_ready = 1'b1;

    mshd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Stage 1: offsets and rotation product
    mshd_prep u_prep (
        .sample         (sample),
        .stick_deadband (cfg.stick_deadband),
        .geometry_sum   (cfg.geometry_sum),
        .prep           (prep_comb)
    );

    // Stage 2: divide, mix, bridge mapping
    mshd_mix u_mix (
        .prep           (prep_reg),
        .motor_deadband (cfg.motor_deadband),
        .drive          (drive_comb)
    );

    // Handshake: output slot frees when empty or being taken this cycle
    assign out_free     = !drive_valid_reg || drive_ready;
    assign sample_ready = !prep_valid_reg || out_free;
    assign take         = sample_valid && sample_ready;

    always_comb
    begin
        if (take)
            prep_valid_next = 1'b1;
        else if (out_free)
            prep_valid_next = 1'b0;
        else
            prep_valid_next = prep_valid_reg;

        drive_valid_next = out_free ? prep_valid_reg : drive_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg  <= 1'b0;
            drive_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg  <= prep_valid_next;
            drive_valid_reg <= drive_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
            prep_reg <= prep_comb;
        if (out_free && prep_valid_reg)
            drive_reg <= drive_comb;
    end

    assign drive_valid = drive_valid_reg;
    assign drive       = drive_reg;

endmodule
